FILE: src/tcs_pkg.sv
// ---------------------------------------------------------------------------
// tcs_pkg
// shared types and constants for the thumbnail composite/scale unit
// ---------------------------------------------------------------------------
package tcs_pkg;

   localparam int CfgIdxW = 3;
   localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CfgIdxW-1:0] REG_BOX_WIDTH  = 3'd2;
   localparam logic [CfgIdxW-1:0] REG_BOX_HEIGHT = 3'd3;
   localparam logic [CfgIdxW-1:0] REG_BG_COLOR   = 3'd4;

   localparam logic [8:0]  BOX_LIMIT    = 9'd256;
   localparam logic [8:0]  BOX_W_RESET  = 9'd200;
   localparam logic [8:0]  BOX_H_RESET  = 9'd240;
   localparam logic [23:0] BG_RESET     = 24'h1d2430;
   localparam logic [7:0]  MASK_R5      = 8'hF8;
   localparam logic [7:0]  MASK_G6      = 8'hFC;
   localparam logic [15:0] BLEND_ROUND  = 16'd127;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EMIT = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel565;
      logic [8:0]  out_width;
      logic [8:0]  out_height;
      logic        last_pixel;
      logic        status;
   } rsp_type;

   // x / 255 rounded down, x < 65280: q = (x + (x>>8) + 1) >> 8
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

FILE: src/tcs_divider.sv
// ---------------------------------------------------------------------------
// tcs_divider
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tcs_divider #(
   parameter int W = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};
      if (go) begin
         rem_in = '0; quo_in = num; den_in = den;
         cnt_in = CW'(W); run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

FILE: src/thumbnail_composite_scale_rgb565_unit.sv
// ---------------------------------------------------------------------------
// thumbnail_composite_scale_rgb565_unit
// loads an rgba frame blended over a background, emits a fitted bilinear
// rgb565 thumbnail one pixel per request
// ---------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  request  | start, busy, req_word              | taken when start & !busy
//  result   | rsp_valid, rsp_word                | one-cycle strobe, no stall
//  config   | csr_we, csr_index, csr_wdata       | written when csr_we high
//
// a load keeps the unit busy for seven steps through the shared
// multiplier and one store write.
// an emit request keeps it busy for three passes of the 28-bit serial divider
// (fit size, row coordinate, column coordinate), the four frame reads, twelve
// multiplier steps and the vertical blend, and the range check and addressing.
// a request before the frame is loaded ends after the fit pass with a status
// word. the word is strobed in the first idle cycle. reset clears all control
// state; the frame store is not cleared. the result cannot be stalled.
module thumbnail_composite_scale_rgb565_unit #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tcs_pkg::req_type     req_word,
   output logic                 rsp_valid,
   output tcs_pkg::rsp_type     rsp_word,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_wdata
);
   import tcs_pkg::*;

   localparam int XW    = $clog2(MAX_SRC_WIDTH);
   localparam int YW    = $clog2(MAX_SRC_HEIGHT);
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = XW + YW;
   localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int CNTW  = AW + 1;
   localparam int DW    = 20 + ((XW > YW) ? XW : YW);

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_FIT, S_FITW, S_CHK, S_QY, S_QYW, S_QX, S_QXW,
      S_ADDR, S_RD, S_MUL, S_PACK
   } state_type;

   // configuration
   logic [8:0]  sw_reg_ff, sh_reg_ff, bw_reg_ff, bh_reg_ff;
   logic [23:0] bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_reg_ff <= 9'd1; sh_reg_ff <= 9'd1;
         bw_reg_ff <= BOX_W_RESET; bh_reg_ff <= BOX_H_RESET; bg_ff <= BG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:  sw_reg_ff <= csr_wdata[8:0];
            REG_SRC_HEIGHT: sh_reg_ff <= csr_wdata[8:0];
            REG_BOX_WIDTH:  bw_reg_ff <= csr_wdata[8:0];
            REG_BOX_HEIGHT: bh_reg_ff <= csr_wdata[8:0];
            REG_BG_COLOR:   bg_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturated sizes
   logic [SWW-1:0] sw;
   logic [SHW-1:0] sh;
   logic [8:0]     bw, bh;
   always_comb begin
      if (sw_reg_ff == 9'd0) sw = SWW'(1);
      else if (32'(sw_reg_ff) > MAX_SRC_WIDTH) sw = SWW'(MAX_SRC_WIDTH);
      else sw = SWW'(sw_reg_ff);
      if (sh_reg_ff == 9'd0) sh = SHW'(1);
      else if (32'(sh_reg_ff) > MAX_SRC_HEIGHT) sh = SHW'(MAX_SRC_HEIGHT);
      else sh = SHW'(sh_reg_ff);
      bw = (bw_reg_ff == 9'd0) ? 9'd1 : ((bw_reg_ff > BOX_LIMIT) ? BOX_LIMIT : bw_reg_ff);
      bh = (bh_reg_ff == 9'd0) ? 9'd1 : ((bh_reg_ff > BOX_LIMIT) ? BOX_LIMIT : bh_reg_ff);
   end

   // frame store
   logic [23:0]   mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [23:0]   mem_wdata, mem_rdata_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // shared multiplier: 17 x 17 unsigned, registered result
   logic [16:0] mul_a, mul_b;
   logic [33:0] mul_p_ff;
   always_ff @(posedge clock) mul_p_ff <= mul_a * mul_b;

   // shared divider
   logic          div_go, div_done;
   logic [DW-1:0] div_num, div_den, div_quo;
   tcs_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo)
   );

   state_type       state_ff;
   logic [CNTW-1:0] load_cnt_ff;
   logic [7:0]      col_ff, row_ff;
   logic [8:0]      dw_ff, dh_ff;
   logic            fitw_ff;     // fit: true when width is the divided side
   logic [4:0]      step_ff;
   logic [7:0]      a_ff;
   logic [7:0]      cr_ff, cg_ff, cb_ff;
   logic [16:0]     acc_ff;
   logic [DW-1:0]   qy_ff, qx_ff;
   logic [YW-1:0]   y0_ff, y1_ff;
   logic [XW-1:0]   x0_ff, x1_ff;
   logic [23:0]     p_ff [4];
   logic [7:0]      v_ff [2];
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [CNTW-1:0] total;
   logic [17:0]     lhs, rhs;
   assign total = CNTW'(sw) * CNTW'(sh);
   assign lhs   = 18'(sw) * 18'(bh);
   assign rhs   = 18'(sh) * 18'(bw);

   // channel picks
   logic [7:0] wx, wy;
   assign wx = qx_ff[7:0];
   assign wy = qy_ff[7:0];

   function automatic logic [7:0] ch(input logic [23:0] p, input logic [1:0] c);
      case (c)
         2'd0:    return p[23:16];
         2'd1:    return p[15:8];
         default: return p[7:0];
      endcase
   endfunction

   logic [1:0] cidx;
   logic [1:0] sub;
   assign cidx = step_ff[3:2];
   assign sub  = step_ff[1:0];

   // multiplier operand select
   always_comb begin
      mul_a = '0; mul_b = '0;
      case (state_ff)
         S_LOAD: begin
            // colour*a then bg*(255-a), one channel per step pair
            case (step_ff[2:0])
               3'd0: begin mul_a = 17'(cr_ff); mul_b = 17'(a_ff); end
               3'd1: begin mul_a = 17'(bg_ff[23:16]); mul_b = 17'(8'd255 - a_ff); end
               3'd2: begin mul_a = 17'(cg_ff); mul_b = 17'(a_ff); end
               3'd3: begin mul_a = 17'(bg_ff[15:8]); mul_b = 17'(8'd255 - a_ff); end
               3'd4: begin mul_a = 17'(cb_ff); mul_b = 17'(a_ff); end
               3'd5: begin mul_a = 17'(bg_ff[7:0]); mul_b = 17'(8'd255 - a_ff); end
               default: ;
            endcase
         end
         S_MUL: begin
            case (sub)
               2'd0: begin mul_a = 17'(ch(p_ff[0], cidx)); mul_b = 17'(9'd256 - 9'(wx)); end
               2'd1: begin mul_a = 17'(ch(p_ff[1], cidx)); mul_b = 17'(wx); end
               2'd2: begin mul_a = 17'(ch(p_ff[2], cidx)); mul_b = 17'(9'd256 - 9'(wx)); end
               default: begin mul_a = 17'(ch(p_ff[3], cidx)); mul_b = 17'(wx); end
            endcase
         end
         default: ;
      endcase
   end

   // vertical blend of the top and bottom sums, taken once both are complete
   logic [16:0] top_ff, bot_ff;
   logic [33:0] vsum;
   logic [7:0]  vb;
   assign vsum = 34'(top_ff) * 34'(9'd256 - 9'(wy)) + 34'(bot_ff) * 34'(wy);
   assign vb   = 8'((vsum + 34'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; load_cnt_ff <= '0; col_ff <= '0; row_ff <= '0;
         dw_ff <= '0; dh_ff <= '0; rsp_valid_ff <= 1'b0; step_ff <= '0;
      end else begin
         rsp_valid_ff <= ((state_ff == S_CHK) && (load_cnt_ff < total)) ||
                         ((state_ff == S_MUL) && (step_ff == 5'd13));
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff <= req_word.alpha; cr_ff <= req_word.red;
                  cg_ff <= req_word.green; cb_ff <= req_word.blue;
                  step_ff <= '0;
                  if (req_word.kind == KIND_LOAD) begin
                     if (load_cnt_ff < total) state_ff <= S_LOAD;
                  end else begin
                     fitw_ff  <= lhs <= rhs;
                     state_ff <= S_FIT;
                  end
               end
            end
            S_LOAD: begin
               // product of step n lands in mul_p_ff at step n+1
               step_ff <= step_ff + 1'b1;
               case (step_ff[2:0])
                  3'd1, 3'd3, 3'd5: acc_ff <= 17'(mul_p_ff);
                  default: ;
               endcase
               case (step_ff[2:0])
                  3'd2: cr_ff <= div255(16'(acc_ff + 17'(mul_p_ff) + 17'(BLEND_ROUND)));
                  3'd4: cg_ff <= div255(16'(acc_ff + 17'(mul_p_ff) + 17'(BLEND_ROUND)));
                  3'd6: begin
                     cb_ff <= div255(16'(acc_ff + 17'(mul_p_ff) + 17'(BLEND_ROUND)));
                     state_ff <= S_PACK;
                  end
                  default: ;
               endcase
            end
            S_PACK: begin
               load_cnt_ff <= load_cnt_ff + 1'b1;
               state_ff    <= S_IDLE;
            end
            S_FIT:  state_ff <= S_FITW;
            S_FITW: if (div_done) begin
               if (fitw_ff) begin
                  dh_ff <= bh;
                  dw_ff <= (div_quo == '0) ? 9'd1 : 9'(div_quo);
               end else begin
                  dw_ff <= bw;
                  dh_ff <= (div_quo == '0) ? 9'd1 : 9'(div_quo);
               end
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (load_cnt_ff < total) begin
                  rsp_ff <= '{pixel565: 16'd0, out_width: dw_ff, out_height: dh_ff,
                              last_pixel: 1'b0, status: 1'b1};
                  state_ff <= S_IDLE;
               end else begin
                  if (9'(col_ff) >= dw_ff || 9'(row_ff) >= dh_ff) begin
                     col_ff <= '0; row_ff <= '0;
                  end
                  state_ff <= S_QY;
               end
            end
            S_QY: state_ff <= S_QYW;
            S_QYW: if (div_done) begin
               qy_ff    <= (dh_ff == 9'd1) ? '0 : div_quo;
               state_ff <= S_QX;
            end
            S_QX: state_ff <= S_QXW;
            S_QXW: if (div_done) begin
               qx_ff    <= (dw_ff == 9'd1) ? '0 : div_quo;
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               y0_ff <= (qy_ff[DW-1:8] > (DW-8)'(sh - 1'b1)) ? YW'(sh - 1'b1)
                                                            : YW'(qy_ff[DW-1:8]);
               x0_ff <= (qx_ff[DW-1:8] > (DW-8)'(sw - 1'b1)) ? XW'(sw - 1'b1)
                                                            : XW'(qx_ff[DW-1:8]);
               step_ff  <= '0;
               state_ff <= S_RD;
            end
            S_RD: begin
               if (step_ff == 5'd0) begin
                  y1_ff <= (32'(y0_ff) + 1 < 32'(sh)) ? y0_ff + 1'b1 : y0_ff;
                  x1_ff <= (32'(x0_ff) + 1 < 32'(sw)) ? x0_ff + 1'b1 : x0_ff;
               end
               // read data is registered, so it arrives on the step after its address
               if (step_ff != 5'd0) p_ff[step_ff[1:0] - 2'd1] <= mem_rdata_ff;
               if (step_ff == 5'd4) begin
                  step_ff  <= '0;
                  state_ff <= S_MUL;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_MUL: begin
               // product of sub n arrives at sub n+1; vertical blend on the
               // cycle after the bottom pair completes
               step_ff <= step_ff + 1'b1;
               case (sub)
                  2'd1: top_ff <= 17'(mul_p_ff);
                  2'd2: top_ff <= top_ff + 17'(mul_p_ff);
                  2'd3: bot_ff <= 17'(mul_p_ff);
                  default: if (step_ff != 5'd0) begin
                     bot_ff <= bot_ff + 17'(mul_p_ff);
                  end
               endcase
               if (sub == 2'd1 && step_ff >= 5'd5 && step_ff < 5'd13) begin
                  v_ff[1'(cidx - 2'd1)] <= vb;
               end
               if (step_ff == 5'd13) begin
                  state_ff <= S_IDLE;
                  rsp_ff <= '{pixel565: {v_ff[0][7:3], v_ff[1][7:2], vb[7:3]},
                              out_width: dw_ff, out_height: dh_ff,
                              last_pixel: (9'(col_ff) == dw_ff - 1'b1) &&
                                          (9'(row_ff) == dh_ff - 1'b1),
                              status: 1'b0};
                  if (9'(col_ff) + 9'd1 >= dw_ff) begin
                     col_ff <= '0;
                     row_ff <= (9'(row_ff) + 9'd1 >= dh_ff) ? 8'd0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // divider feed and frame access
   logic [AW-1:0] rd_addr;
   always_comb begin
      div_go = 1'b0; div_num = '0; div_den = DW'(1);
      case (state_ff)
         S_FIT: begin
            div_go  = 1'b1;
            div_num = fitw_ff ? DW'(18'(sw) * 18'(bh)) : DW'(18'(sh) * 18'(bw));
            div_den = fitw_ff ? DW'(sh) : DW'(sw);
         end
         S_QY: begin
            div_go  = 1'b1;
            div_num = DW'({20'(row_ff) * 20'(sh - 1'b1), 8'd0});
            div_den = (dh_ff > 9'd1) ? DW'(dh_ff - 9'd1) : DW'(1);
         end
         S_QX: begin
            div_go  = 1'b1;
            div_num = DW'({20'(col_ff) * 20'(sw - 1'b1), 8'd0});
            div_den = (dw_ff > 9'd1) ? DW'(dw_ff - 9'd1) : DW'(1);
         end
         default: ;
      endcase
      case (step_ff[1:0])
         2'd0:    rd_addr = AW'(y0_ff) * AW'(sw) + AW'(x0_ff);
         2'd1:    rd_addr = AW'(y0_ff) * AW'(sw) + AW'(x1_ff);
         2'd2:    rd_addr = AW'(y1_ff) * AW'(sw) + AW'(x0_ff);
         default: rd_addr = AW'(y1_ff) * AW'(sw) + AW'(x1_ff);
      endcase
      mem_raddr = rd_addr;
      mem_we    = (state_ff == S_PACK);
      mem_waddr = load_cnt_ff[AW-1:0];
      mem_wdata = {cr_ff, cg_ff, cb_ff};
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      32'(load_cnt_ff) <= DEPTH) else $error("load count past store");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("result while busy");
   a_pos_in: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.status) |-> (9'(col_ff) < dw_ff))
      else $error("column out of range");
`endif
endmodule
